>>> src/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

	// Fixed field widths
	localparam int PRICE_W     = 24;
	localparam int SQR_W       = 2 * PRICE_W;
	localparam int STD_W       = 31;
	localparam int CFG_W       = 7;
	localparam int OUT_TDATA_W = 32;

	// Window length after reset
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd5;

	// Top-level sequencer: sample bookkeeping and result hand-off
	typedef enum logic [2:0] {
		T_IDLE,
		T_UPD,
		T_SUB,
		T_CALC,
		T_EMIT
	} top_state_t;

	// Arithmetic engine sequencer
	typedef enum logic [2:0] {
		C_IDLE,
		C_MULQ,
		C_MULS,
		C_DIFF,
		C_SQRT,
		C_DIV,
		C_DONE
	} calc_state_t;

endpackage

`default_nettype wire

>>> src/rolling_std_deviation_core.sv
// Sliding-window population standard deviation of a price stream.
//
// Input stream s_axis: one 24-bit price sample per transfer. Output stream
// m_axis: one result per sample, tdata = std_dev (8 fraction bits by default,
// rounded down), tuser = window_full. Until the window holds window_length
// samples the result is 0 with window_full low.
// Config channel cfg: a write sets window_length (0 acts as 1, values above
// WINDOW_MAX clamp) and restarts the window. Write only while the block is idle.
//
// While the window is filling, a sample goes from input transfer through the
// update, subtract and emit states to the result. Once full, a shared
// add/subtract unit runs N*Q, S*S, the digit-by-digit square root and the
// restoring divide by N one step per cycle, with s_axis_tready low meanwhile;
// the next sample is taken once the sequencer is back in idle.
// The result sits in an output register; a stalled receiver only holds the
// block once a second result is ready to be loaded behind it.
// Reset clears the window, the running sums and the output valid flag and sets
// window_length to 5. The sample ring needs no clearing: entries are read only
// once the window is full.
`default_nettype none

module rolling_std_deviation_core #(
	parameter int WINDOW_MAX    = 64,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rsd_pkg::CFG_W-1:0]         cfg_data,

	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [rsd_pkg::PRICE_W-1:0]       s_axis_tdata,   // [23:0] price_sample

	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic      [rsd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [30:0] std_dev, [31] zero
	output logic                                   m_axis_tuser    // [0] window_full
);

	import rsd_pkg::*;

	localparam int L     = $clog2(WINDOW_MAX);
	localparam int NW    = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = PRICE_W + L;
	localparam int SQ_W  = 2 * PRICE_W + L;
	localparam int CMP_W = (NW > CFG_W) ? NW : CFG_W;

	function automatic logic [NW-1:0] clamp_window(input logic [CFG_W-1:0] w);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(w);
		if (w == '0) begin
			return NW'(1);
		end else if (wide > CMP_W'(WINDOW_MAX)) begin
			return NW'(WINDOW_MAX);
		end else begin
			return NW'(w);
		end
	endfunction

	top_state_t         state_q, state_d;
	logic [NW-1:0]      n_q;
	logic [L-1:0]       ptr_q;
	logic [L-1:0]       p_q;
	logic [NW-1:0]      fill_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sqsum_q;
	logic [PRICE_W-1:0] x_q;
	logic [SQR_W-1:0]   sq_q;
	logic               fb_q;
	logic               out_valid_q;
	logic [STD_W-1:0]   out_std_q;
	logic               out_full_q;

	logic               in_xfer, cfg_xfer, out_free;
	logic               calc_start, calc_done, calc_busy;
	logic [STD_W-1:0]   calc_std;
	logic               full_now;
	logic [L-1:0]       p_sel;
	logic [NW-1:0]      p_inc;
	logic [PRICE_W-1:0] ring_rd;
	logic [PRICE_W-1:0] mul_in;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign full_now = (fill_q >= n_q);

	// Ring slot for this sample and the slot after it
	assign p_sel = (NW'(ptr_q) >= n_q) ? '0 : ptr_q;
	assign p_inc = NW'(p_q) + 1'b1;

	rsd_ring #(
		.DEPTH  (WINDOW_MAX),
		.DATA_W (PRICE_W)
	) u_ring (
		.clk   (clk),
		.wen   (in_xfer),
		.addr  (p_sel),
		.wdata (s_axis_tdata),
		.rdata (ring_rd)
	);

	rsd_calc #(
		.WINDOW_MAX    (WINDOW_MAX),
		.FRACTION_BITS (FRACTION_BITS)
	) u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (calc_start),
		.n       (n_q),
		.sum     (sum_q),
		.sqsum   (sqsum_q),
		.done    (calc_done),
		.busy    (calc_busy),
		.std_dev (calc_std)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: if (in_xfer) state_d = T_UPD;
			T_UPD:  state_d = T_SUB;
			T_SUB:  state_d = full_now ? T_CALC : T_EMIT;
			T_CALC: if (calc_done) state_d = T_EMIT;
			T_EMIT: if (out_free) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	// Handshakes and engine start
	always_comb begin
		s_axis_tready = 1'b0;
		cfg_ready     = 1'b0;
		calc_start    = 1'b0;
		unique case (state_q)
			T_IDLE: begin
				cfg_ready     = 1'b1;
				s_axis_tready = !cfg_valid;
			end
			// sums settle at the end of this cycle, before the engine reads them
			T_SUB:  calc_start = full_now;
			T_UPD, T_CALC, T_EMIT: calc_start = 1'b0;
			default: calc_start = 1'b0;
		endcase
	end

	// Squarer: new sample at input transfer, evicted sample in the cycle after it
	assign mul_in = (state_q == T_IDLE) ? s_axis_tdata : ring_rd;

	always_ff @(posedge clk) begin
		sq_q <= SQR_W'(mul_in) * SQR_W'(mul_in);
		if (in_xfer) begin
			x_q  <= s_axis_tdata;
			p_q  <= p_sel;
			fb_q <= full_now;
		end
		if (state_q == T_EMIT && out_free) begin
			out_std_q  <= full_now ? calc_std : '0;
			out_full_q <= full_now;
		end
	end

	// Window bookkeeping, running sums and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			n_q         <= clamp_window(WINDOW_RESET);
			ptr_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sqsum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_xfer) begin
				n_q     <= clamp_window(cfg_data);
				ptr_q   <= '0;
				fill_q  <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
			end
			if (state_q == T_UPD) begin
				sum_q   <= sum_q + SUM_W'(x_q) - (fb_q ? SUM_W'(ring_rd) : '0);
				sqsum_q <= sqsum_q + SQ_W'(sq_q);
				ptr_q   <= (p_inc >= n_q) ? '0 : p_inc[L-1:0];
				if (fill_q < n_q) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			// drop the evicted square
			if (state_q == T_SUB && fb_q) begin
				sqsum_q <= sqsum_q - SQ_W'(sq_q);
			end
			if (state_q == T_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_std_q);
	assign m_axis_tuser  = out_full_q;

	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == T_UPD)
		else $error("sample transfer not followed by update");

	a_ptr_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(NW'(ptr_q) < n_q) && (fill_q <= n_q))
		else $error("ring pointer or fill count outside window");

	a_partial_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("nonzero result before window is full");

	a_calc_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		calc_busy |-> (state_q == T_CALC) && full_now)
		else $error("engine running outside calc state");

endmodule

`default_nettype wire

>>> src/rsd_ring.sv
`default_nettype none

module rsd_ring #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 24
) (
	input  wire logic                     clk,
	input  wire logic                     wen,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Single port, read-before-write: rdata gets the old entry
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

>>> src/rsd_calc.sv
`default_nettype none

module rsd_calc #(
	parameter int WINDOW_MAX    = 64,
	parameter int FRACTION_BITS = 8
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             start,
	input  wire logic [$clog2(WINDOW_MAX+1)-1:0]                  n,
	input  wire logic [rsd_pkg::PRICE_W+$clog2(WINDOW_MAX)-1:0]   sum,
	input  wire logic [2*rsd_pkg::PRICE_W+$clog2(WINDOW_MAX)-1:0] sqsum,
	output logic                                                  done,
	output logic                                                  busy,
	output logic      [rsd_pkg::STD_W-1:0]                        std_dev
);

	import rsd_pkg::*;

	localparam int L     = $clog2(WINDOW_MAX);
	localparam int NW    = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = PRICE_W + L;
	// D = N*Q - S*S fits in twice the sum width; wide enough for the root remainder too
	localparam int A_W   = 2 * SUM_W;
	localparam int R_W   = SUM_W + FRACTION_BITS;
	localparam int Q_W   = (R_W > STD_W) ? R_W : STD_W;
	localparam int CW    = $clog2(R_W);

	calc_state_t       state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [A_W-1:0]    acc_q;
	logic [A_W-1:0]    t_q;
	logic [SUM_W-1:0]  m_q;
	logic [R_W-1:0]    root_q;

	logic [A_W-1:0]    op_a, op_b;
	logic              op_sub;
	logic [A_W:0]      add_res;
	logic              carry;
	logic              last;
	logic [A_W-1:0]    rem_sqrt, rem_div;
	logic [Q_W-1:0]    root_wide;

	// Shared add/subtract unit; carry out of a subtract means a >= b
	assign add_res = {1'b0, op_a} + {1'b0, op_b ^ {A_W{op_sub}}} + (A_W+1)'(op_sub);
	assign carry   = add_res[A_W];
	assign last    = (cnt_q == '0);

	// Shifted partial remainders for square root (two bits of D) and divide (one root bit)
	assign rem_sqrt = {t_q[A_W-3:0], acc_q[A_W-1:A_W-2]};
	assign rem_div  = {t_q[A_W-2:0], root_q[R_W-1]};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (start) state_d = C_MULQ;
			C_MULQ: if (last) state_d = C_MULS;
			C_MULS: if (last) state_d = C_DIFF;
			C_DIFF: state_d = C_SQRT;
			C_SQRT: if (last) state_d = C_DIV;
			C_DIV:  if (last) state_d = C_DONE;
			C_DONE: state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	// Operand selection and status
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		done   = 1'b0;
		busy   = 1'b1;
		unique case (state_q)
			C_IDLE: busy = 1'b0;
			C_MULQ: begin
				op_a = {acc_q[A_W-2:0], 1'b0};
				op_b = m_q[SUM_W-1] ? A_W'(sqsum) : '0;
			end
			C_MULS: begin
				op_a = {t_q[A_W-2:0], 1'b0};
				op_b = m_q[SUM_W-1] ? A_W'(sum) : '0;
			end
			C_DIFF: begin
				op_a   = acc_q;
				op_b   = t_q;
				op_sub = 1'b1;
			end
			C_SQRT: begin
				op_a   = rem_sqrt;
				op_b   = A_W'({root_q, 2'b01});
				op_sub = 1'b1;
			end
			C_DIV: begin
				op_a   = rem_div;
				op_b   = A_W'(n);
				op_sub = 1'b1;
			end
			C_DONE: done = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				C_IDLE: if (start) cnt_q <= CW'(NW - 1);
				C_MULQ: cnt_q <= last ? CW'(SUM_W - 1) : cnt_q - 1'b1;
				C_DIFF: cnt_q <= CW'(R_W - 1);
				C_SQRT: cnt_q <= last ? CW'(R_W - 1) : cnt_q - 1'b1;
				C_MULS, C_DIV: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					// window length left-aligned so its top bit drives the first step
					m_q   <= SUM_W'(n) << (SUM_W - NW);
					acc_q <= '0;
					t_q   <= '0;
				end
			end
			C_MULQ: begin
				acc_q <= add_res[A_W-1:0];
				m_q   <= last ? sum : {m_q[SUM_W-2:0], 1'b0};
			end
			C_MULS: begin
				t_q <= add_res[A_W-1:0];
				m_q <= {m_q[SUM_W-2:0], 1'b0};
			end
			C_DIFF: begin
				acc_q  <= add_res[A_W-1:0];
				t_q    <= '0;
				root_q <= '0;
			end
			C_SQRT: begin
				acc_q  <= {acc_q[A_W-3:0], 2'b00};
				root_q <= {root_q[R_W-2:0], carry};
				if (last) begin
					t_q <= '0;
				end else begin
					t_q <= carry ? add_res[A_W-1:0] : rem_sqrt;
				end
			end
			C_DIV: begin
				// quotient bits shift in behind the root bits
				root_q <= {root_q[R_W-2:0], carry};
				t_q    <= carry ? add_res[A_W-1:0] : rem_div;
			end
			default: begin
				root_q <= root_q;
			end
		endcase
	end

	// Saturate to the output width
	assign root_wide = Q_W'(root_q);
	assign std_dev   = (root_wide > Q_W'({STD_W{1'b1}})) ? '1 : STD_W'(root_wide);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == C_IDLE)
		else $error("calc started while busy");

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == C_IDLE) && !busy)
		else $error("calc did not return to idle after done");

	a_div_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_DIV && last) |=> done)
		else $error("done missing after last divide step");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
	import rsd_pkg::*;

	localparam int WIN_MAX        = 64;
	localparam int FRAC_BITS      = 8;
	localparam int RANDOM_ITEMS   = 500;
	localparam int IDLE_PCT       = 37;
	localparam int STALL_LIMIT    = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 150;
	localparam int DIRECTED_COUNT = 23;

	localparam logic [STD_W-1:0] STD_CEILING = {STD_W{1'b1}};
	localparam logic [PRICE_W-1:0] PRICE_TOP = {PRICE_W{1'b1}};

	// One expected result
	typedef struct packed {
		logic [STD_W-1:0] std_dev;
		logic             window_full;
	} dev_result_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WINDOW
	} row_kind_t;

	// Directed row: a price transfer or a window_length write
	typedef struct packed {
		row_kind_t        kind;
		logic [PRICE_W-1:0] value;
		logic             known;
		logic [STD_W-1:0] std_dev;
		logic             window_full;
	} stim_row_t;

	logic clk;
	logic arst_n;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data = '0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [PRICE_W-1:0]     s_axis_tdata = '0;   // [23:0] price_sample

	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [30:0] std_dev, [31] zero
	logic                   m_axis_tuser;        // [0] window_full

	rolling_std_deviation_core #(
		.WINDOW_MAX    (WIN_MAX),
		.FRACTION_BITS (FRAC_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Shadow copy of the window state
	logic [CFG_W-1:0]   window_setting;
	logic [PRICE_W-1:0] price_ring [WIN_MAX];
	int unsigned        ring_slot;
	int unsigned        samples_held;
	logic [29:0]        window_sum;
	logic [53:0]        window_sqsum;

	dev_result_t pending_deviations [$];
	int          mismatch_count = 0;
	bit          calm_stretch = 1'b0;
	stim_row_t   directed_rows [DIRECTED_COUNT];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned live_window(input logic [CFG_W-1:0] setting);
		if (setting == '0)
			return 1;
		if (32'(setting) > WIN_MAX)
			return WIN_MAX;
		return 32'(setting);
	endfunction

	// floor(sqrt(d * 4^FRAC_BITS)), one result bit per step
	function automatic logic [39:0] scaled_root(input logic [63:0] d);
		logic [79:0] radicand;
		logic [47:0] rem;
		logic [47:0] trial;
		logic [39:0] root;
		radicand = {d, 16'b0} >> (16 - 2 * FRAC_BITS);
		rem = '0;
		root = '0;
		for (int i = 39; i >= 0; i--) begin
			rem = (rem << 2) | 48'(radicand[2*i +: 2]);
			trial = 48'({root, 2'b01});
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[38:0], 1'b1};
			end else begin
				root = {root[38:0], 1'b0};
			end
		end
		return root;
	endfunction

	// Advance the shadow window by one price and work out the result
	task automatic predict_deviation(input logic [PRICE_W-1:0] price, output dev_result_t res);
		int unsigned  n;
		int unsigned  slot;
		logic [63:0]  n64;
		logic [63:0]  spread;
		logic [63:0]  quotient;
		logic [PRICE_W-1:0] oldest;
		n = live_window(window_setting);
		n64 = 64'(n);
		slot = ring_slot % WIN_MAX;
		if (slot >= n)
			slot = 0;
		if (samples_held >= n) begin
			oldest = price_ring[slot];
			window_sum = window_sum - 30'(oldest);
			window_sqsum = window_sqsum - 54'(oldest) * 54'(oldest);
		end
		price_ring[slot] = price;
		window_sum = window_sum + 30'(price);
		window_sqsum = window_sqsum + 54'(price) * 54'(price);
		ring_slot = (slot + 1 >= n) ? 0 : slot + 1;
		if (samples_held < n)
			samples_held++;
		if (samples_held >= n) begin
			spread = n64 * 64'(window_sqsum) - 64'(window_sum) * 64'(window_sum);
			quotient = 64'(scaled_root(spread)) / n64;
			res.std_dev = (quotient > 64'(STD_CEILING)) ? STD_CEILING : quotient[STD_W-1:0];
			res.window_full = 1'b1;
		end else begin
			res.std_dev = '0;
			res.window_full = 1'b0;
		end
	endtask

	// Hold the sender until every expected result has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_deviations.size() != 0)
			@(posedge clk);
	endtask

	// window_length write, only with the block idle
	task automatic write_window(input logic [CFG_W-1:0] setting);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= setting;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		window_setting = setting;
		ring_slot = 0;
		samples_held = 0;
		window_sum = '0;
		window_sqsum = '0;
	endtask

	// One price transfer; a typed-in result overrides the prediction
	task automatic send_price(input logic [PRICE_W-1:0] price, input logic known,
			input dev_result_t typed);
		dev_result_t res;
		if (!calm_stretch) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= price;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_deviation(price, res);
		if (known)
			res = typed;
		pending_deviations.push_back(res);
	endtask

	function automatic logic [PRICE_W-1:0] pick_price(input logic [PRICE_W-1:0] base);
		case ($urandom_range(9))
			0: return '0;
			1: return PRICE_TOP;
			2, 3, 4: return PRICE_W'($urandom);
			default: return PRICE_W'(base + $urandom_range(255));
		endcase
	endfunction

	// Receiver stalls
	always @(posedge clk) begin
		m_axis_tready <= calm_stretch ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// Result checker
	always @(posedge clk) begin
		dev_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_deviations.size() == 0) begin
				$display("%0t: unexpected result std_dev %h window_full %b", $time,
					m_axis_tdata[STD_W-1:0], m_axis_tuser);
				mismatch_count++;
			end else begin
				want = pending_deviations.pop_front();
				if (m_axis_tdata[STD_W-1:0] !== want.std_dev) begin
					$display("%0t: std_dev expected %h actual %h", $time,
						want.std_dev, m_axis_tdata[STD_W-1:0]);
					mismatch_count++;
				end
				if (m_axis_tuser !== want.window_full) begin
					$display("%0t: window_full expected %b actual %b", $time,
						want.window_full, m_axis_tuser);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer at all
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	// Stimulus
	initial begin
		int unsigned items_sent;
		int unsigned phase;
		int unsigned phase_items;
		logic [CFG_W-1:0]   setting;
		logic [PRICE_W-1:0] base;

		// reset edge at time zero
		arst_n <= 1'b0;

		// Window restarts, extremes, eviction, clamped window lengths
		directed_rows = '{
			'{ROW_SAMPLE, 24'h000000, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h123456, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h000007, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h800000, 1'b0, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h000001, 1'b0, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'hFFFFFF, 1'b0, 31'h0, 1'b0},
			'{ROW_WINDOW, 24'd0,      1'b0, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 31'h0, 1'b1},
			'{ROW_SAMPLE, 24'h000000, 1'b1, 31'h0, 1'b1},
			'{ROW_WINDOW, 24'd2,      1'b0, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h000000, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'hFFFFFF, 1'b1, 31'h7FFFFF80, 1'b1},
			'{ROW_SAMPLE, 24'h000000, 1'b1, 31'h7FFFFF80, 1'b1},
			'{ROW_SAMPLE, 24'h000000, 1'b1, 31'h0, 1'b1},
			'{ROW_WINDOW, 24'd127,    1'b0, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'hABCDEF, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h543210, 1'b1, 31'h0, 1'b0},
			'{ROW_WINDOW, 24'd3,      1'b0, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h000010, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h000020, 1'b1, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h000030, 1'b0, 31'h0, 1'b0},
			'{ROW_SAMPLE, 24'h000040, 1'b0, 31'h0, 1'b0}
		};

		window_setting = WINDOW_RESET;
		ring_slot = 0;
		samples_held = 0;
		window_sum = '0;
		window_sqsum = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WINDOW)
				write_window(directed_rows[i].value[CFG_W-1:0]);
			else
				send_price(directed_rows[i].value, directed_rows[i].known,
					'{directed_rows[i].std_dev, directed_rows[i].window_full});
		end

		// Random phases, each with its own window length and price cluster
		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0: setting = CFG_W'(1);
				1: setting = CFG_W'(2);
				2: setting = CFG_W'(WIN_MAX);
				3: setting = CFG_W'($urandom_range(127, WIN_MAX + 1));
				4: setting = '0;
				default: setting = CFG_W'($urandom_range(WIN_MAX, 3));
			endcase
			write_window(setting);
			calm_stretch = (phase == 1);
			base = PRICE_W'($urandom);
			phase_items = live_window(setting) + $urandom_range(60, 10);
			for (int k = 0; k < phase_items; k++) begin
				send_price(pick_price(base), 1'b0, '0);
				items_sent++;
				// mid-phase pause with the window kept intact
				if (phase == 2 && k == phase_items / 2)
					drain_results();
			end
			phase++;
		end
		calm_stretch = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
src/rsd_pkg.sv
src/rsd_ring.sv
src/rsd_calc.sv
src/rolling_std_deviation_core.sv
sim/tb_top.sv
